// ===== sv/i2cms_pkg.sv =====
`default_nettype none

package i2cms_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [4:0] LEN_START_STOP = 5'd4;
    localparam logic [4:0] LEN_WRITE      = 5'd29;
    localparam logic [4:0] LEN_READ       = 5'd22;
    localparam logic [4:0] WR_BITS_END    = 5'd24;
    localparam logic [4:0] RD_BITS_END    = 5'd16;
    localparam logic [4:0] RD_LAST_SAMPLE = 5'd15;

    typedef struct packed {
        logic       kind;
        logic [1:0] command;
        logic [7:0] write_byte;
        logic       sda_sample;
    } t_cmd;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       nack_seen;
        logic       rejected;
    } t_res;

endpackage

`default_nettype wire

// ===== sv/i2cms_cmd_if.sv =====
`default_nettype none

interface i2cms_cmd_if
    import i2cms_pkg::*;
();
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/i2cms_res_if.sv =====
`default_nettype none

interface i2cms_res_if
    import i2cms_pkg::*;
();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/i2c_master_bit_sequencer.sv =====
`default_nettype none

// I2C master bit sequencer. A command transaction (kind 0) loads start, stop,
// write byte or read byte while idle; each tick transaction (kind 1) then
// applies one pin step, and the result of every transaction gives the SCL/SDA
// levels, SDA drive, busy, done, last read byte, last write ACK and a
// rejected flag for a command sent while busy. One transaction is taken per
// clock unless a waiting result is not taken; its result appears in the
// output register in the cycle after it is accepted, and a new transaction
// is taken while that result waits as long as the result is being taken in
// the same cycle. An operation takes 4 (start/stop), 29 (write) or 22 (read)
// ticks. No clock stretching or arbitration.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    i2cms_cmd_if.sink   i_cmd,
    i2cms_res_if.source o_res
);

    logic [4:0] r_step,  n_step;
    logic [1:0] r_phase, n_phase;
    t_op        r_op,    n_op;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_hold,  n_hold;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;
    logic       r_drv,   n_drv;
    logic       r_busy,  n_busy;
    logic       r_ack,   n_ack;
    logic       r_out_valid;
    t_res       r_res,   n_res;

    logic       accept;
    logic [4:0] step_inc;
    logic [4:0] op_len;
    t_cmd       cmd;

    assign cmd          = i_cmd.data;
    assign i_cmd.ready  = !r_out_valid || o_res.ready;
    assign accept       = i_cmd.valid && i_cmd.ready;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_res;
    assign step_inc     = r_step + 5'd1;

    always_comb begin
        case (r_op)
            OP_WRITE: op_len = LEN_WRITE;
            OP_READ:  op_len = LEN_READ;
            default:  op_len = LEN_START_STOP;
        endcase
    end

    always_comb begin
        n_step  = r_step;
        n_phase = r_phase;
        n_op    = r_op;
        n_shift = r_shift;
        n_hold  = r_hold;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        n_busy  = r_busy;
        n_ack   = r_ack;
        n_res   = '0;

        if (cmd.kind == KIND_CMD) begin
            if (r_busy) begin
                n_res.rejected = 1'b1;
            end else begin
                n_op    = t_op'(cmd.command);
                n_step  = 5'd0;
                n_phase = 2'd0;
                n_shift = (t_op'(cmd.command) == OP_WRITE) ? cmd.write_byte : 8'd0;
                n_busy  = 1'b1;
            end
        end else if (r_busy) begin
            case (r_op)
                OP_START: begin
                    case (r_step[1:0])
                        2'd0: begin n_drv = 1'b1; n_sda = 1'b1; end
                        2'd1: n_scl = 1'b1;
                        2'd2: begin n_drv = 1'b1; n_sda = 1'b0; end
                        default: n_scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    case (r_step[1:0])
                        2'd0: begin n_drv = 1'b1; n_sda = 1'b0; end
                        2'd1: n_scl = 1'b0;
                        2'd2: n_scl = 1'b1;
                        default: begin n_drv = 1'b1; n_sda = 1'b1; end
                    endcase
                end
                OP_WRITE: begin
                    if (r_step < WR_BITS_END) begin
                        n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
                        case (r_phase)
                            2'd0: n_scl = 1'b0;
                            2'd1: begin
                                n_drv   = 1'b1;
                                n_sda   = r_shift[7];
                                n_shift = {r_shift[6:0], 1'b0};
                            end
                            default: n_scl = 1'b1;
                        endcase
                    end else begin
                        case (r_step)
                            5'd24: n_scl = 1'b0;
                            5'd25: n_drv = 1'b0;
                            5'd26: begin n_scl = 1'b1; n_ack = cmd.sda_sample; end
                            5'd27: n_scl = 1'b0;
                            default: n_drv = 1'b1;
                        endcase
                    end
                end
                default: begin
                    if (r_step == 5'd0) begin
                        n_drv = 1'b0;
                    end else if (r_step <= RD_BITS_END) begin
                        if (r_step[0]) begin
                            n_scl   = 1'b1;
                            n_shift = {r_shift[6:0], cmd.sda_sample};
                            if (r_step == RD_LAST_SAMPLE) begin
                                n_hold = {r_shift[6:0], cmd.sda_sample};
                            end
                        end else begin
                            n_scl = 1'b0;
                        end
                    end else begin
                        case (r_step)
                            5'd17: n_drv = 1'b1;
                            5'd18: n_scl = 1'b0;
                            5'd19: begin n_drv = 1'b1; n_sda = (r_shift == 8'd0); end
                            5'd20: n_scl = 1'b1;
                            default: n_scl = 1'b0;
                        endcase
                    end
                end
            endcase
            n_step = step_inc;
            if (step_inc >= op_len) begin
                n_busy         = 1'b0;
                n_step         = 5'd0;
                n_res.done_res = 1'b1;
            end
        end

        n_res.scl_level = n_scl;
        n_res.sda_level = n_drv & n_sda;
        n_res.sda_drive = n_drv;
        n_res.busy_res  = n_busy;
        n_res.read_byte = n_hold;
        n_res.nack_seen = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 5'd0;
            r_phase     <= 2'd0;
            r_op        <= OP_START;
            r_shift     <= 8'd0;
            r_hold      <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_drv       <= 1'b1;
            r_busy      <= 1'b0;
            r_ack       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_step  <= n_step;
                r_phase <= n_phase;
                r_op    <= n_op;
                r_shift <= n_shift;
                r_hold  <= n_hold;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_drv   <= n_drv;
                r_busy  <= n_busy;
                r_ack   <= n_ack;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && cmd.kind == KIND_CMD && r_busy |=> r_res.rejected && r_busy)
        else $error("busy command not rejected");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step < op_len)
        else $error("step beyond operation length");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.done_res |-> !r_res.busy_res && r_step == 5'd0)
        else $error("done while still busy");

    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.sda_drive |-> !r_res.sda_level)
        else $error("released SDA reported high");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> r_out_valid && $stable(r_res))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== tb/i2c_master_bit_sequencer_tb.sv =====
module i2c_master_bit_sequencer_tb;
    import i2cms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_cmd item;
        bit   hold;
    } t_plan;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    i2cms_cmd_if cmd_if();
    i2cms_res_if res_if();

    i2c_master_bit_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    t_plan plan_q[$];
    t_res  pin_levels_q[$];

    int sent_cnt;
    int checked_cnt;
    int err_cnt;
    int rej_cnt;
    int ops_done[4];

    // bus model state
    logic [4:0] bus_step;
    t_op        bus_op;
    logic [7:0] bus_shift;
    logic [7:0] bus_rd_hold;
    logic       bus_scl;
    logic       bus_sda;
    logic       bus_drv;
    logic       bus_busy;
    logic       bus_ack;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned op_ticks(t_op op);
        case (op)
            OP_WRITE: return LEN_WRITE;
            OP_READ:  return LEN_READ;
            default:  return LEN_START_STOP;
        endcase
    endfunction

    function automatic bit no_gaps();
        return sent_cnt >= 600 && sent_cnt < 900;
    endfunction

    task automatic sequence_pins(input t_cmd c);
        t_res       r;
        logic [4:0] s;
        logic       done;
        logic       rej;
        done = 1'b0;
        rej  = 1'b0;
        if (c.kind == KIND_CMD) begin
            if (bus_busy) begin
                rej = 1'b1;
            end else begin
                bus_op    = t_op'(c.command);
                bus_step  = '0;
                bus_shift = (bus_op == OP_WRITE) ? c.write_byte : 8'h00;
                bus_busy  = 1'b1;
            end
        end else if (bus_busy) begin
            s = bus_step;
            case (bus_op)
                OP_START: begin
                    case (s)
                        0: begin bus_drv = 1'b1; bus_sda = 1'b1; end
                        1: bus_scl = 1'b1;
                        2: begin bus_drv = 1'b1; bus_sda = 1'b0; end
                        default: bus_scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    case (s)
                        0: begin bus_drv = 1'b1; bus_sda = 1'b0; end
                        1: bus_scl = 1'b0;
                        2: bus_scl = 1'b1;
                        default: begin bus_drv = 1'b1; bus_sda = 1'b1; end
                    endcase
                end
                OP_WRITE: begin
                    if (s < WR_BITS_END) begin
                        case (s % 3)
                            0: bus_scl = 1'b0;
                            1: begin
                                bus_drv   = 1'b1;
                                bus_sda   = bus_shift[7];
                                bus_shift = bus_shift << 1;
                            end
                            default: bus_scl = 1'b1;
                        endcase
                    end else begin
                        case (s)
                            24: bus_scl = 1'b0;
                            25: bus_drv = 1'b0;
                            26: begin bus_scl = 1'b1; bus_ack = c.sda_sample; end
                            27: bus_scl = 1'b0;
                            default: bus_drv = 1'b1;
                        endcase
                    end
                end
                default: begin
                    if (s == 0) begin
                        bus_drv = 1'b0;
                    end else if (s <= RD_BITS_END) begin
                        if (s[0]) begin
                            bus_scl   = 1'b1;
                            bus_shift = {bus_shift[6:0], c.sda_sample};
                            if (s == RD_LAST_SAMPLE) bus_rd_hold = bus_shift;
                        end else begin
                            bus_scl = 1'b0;
                        end
                    end else begin
                        case (s)
                            17: bus_drv = 1'b1;
                            18: bus_scl = 1'b0;
                            19: begin
                                bus_drv = 1'b1;
                                bus_sda = (bus_shift != 8'h00) ? 1'b0 : 1'b1;
                            end
                            20: bus_scl = 1'b1;
                            default: bus_scl = 1'b0;
                        endcase
                    end
                end
            endcase
            bus_step = s + 5'd1;
            if (bus_step >= op_ticks(bus_op)) begin
                bus_busy = 1'b0;
                bus_step = '0;
                done     = 1'b1;
                ops_done[bus_op]++;
            end
        end
        rej_cnt += rej;
        r.scl_level = bus_scl;
        r.sda_level = bus_drv ? bus_sda : 1'b0;
        r.sda_drive = bus_drv;
        r.busy_res  = bus_busy;
        r.done_res  = done;
        r.read_byte = bus_rd_hold;
        r.nack_seen = bus_ack;
        r.rejected  = rej;
        pin_levels_q.push_back(r);
    endtask

    task automatic add(logic kind, t_op op, logic [7:0] wb, logic samp, bit hold = 1'b0);
        t_plan p;
        p.item.kind       = kind;
        p.item.command    = op;
        p.item.write_byte = wb;
        p.item.sda_sample = samp;
        p.hold            = hold;
        plan_q.push_back(p);
    endtask

    task automatic add_op(t_op op, bit hold);
        logic [7:0]  wb;
        int unsigned pat;
        int unsigned n;
        logic        samp;
        case ($urandom_range(7))
            0:       wb = 8'h00;
            1:       wb = 8'hFF;
            default: wb = 8'($urandom_range(255));
        endcase
        pat = $urandom_range(5);
        add(KIND_CMD, op, wb, 1'($urandom_range(1)), hold);
        n = op_ticks(op);
        if ($urandom_range(19) == 0) n = $urandom_range(n - 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(32) == 0)
                add(KIND_CMD, t_op'($urandom_range(3)), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
            samp = (pat == 0) ? 1'b0 : (pat == 1) ? 1'b1 : 1'($urandom_range(1));
            add(KIND_TICK, t_op'($urandom_range(3)), 8'($urandom_range(255)), samp);
        end
    endtask

    function automatic void cmp(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                sequence_pins(cmd_if.data);
                sent_cnt++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (plan_q.size() > 0 && !(plan_q[0].hold && pin_levels_q.size() > 0)
                        && (no_gaps() || $urandom_range(99) >= 8)) begin
                    cmd_if.data  <= plan_q[0].item;
                    cmd_if.valid <= 1'b1;
                    void'(plan_q.pop_front());
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        t_res a;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                a = res_if.data;
                if (pin_levels_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h", $time, a);
                    err_cnt++;
                end else begin
                    e = pin_levels_q.pop_front();
                    checked_cnt++;
                    cmp("scl_level", e.scl_level, a.scl_level);
                    cmp("sda_level", e.sda_level, a.sda_level);
                    cmp("sda_drive", e.sda_drive, a.sda_drive);
                    cmp("busy_res", e.busy_res, a.busy_res);
                    cmp("done_res", e.done_res, a.done_res);
                    cmp("read_byte", e.read_byte, a.read_byte);
                    cmp("nack_seen", e.nack_seen, a.nack_seen);
                    cmp("rejected", e.rejected, a.rejected);
                end
            end
            res_if.ready <= no_gaps() || $urandom_range(99) >= 8;
        end
    end

    initial begin
        int op_no;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        res_if.ready = 1'b0;

        bus_step    = '0;
        bus_op      = OP_START;
        bus_shift   = 8'h00;
        bus_rd_hold = 8'h00;
        bus_scl     = 1'b1;
        bus_sda     = 1'b1;
        bus_drv     = 1'b1;
        bus_busy    = 1'b0;
        bus_ack     = 1'b0;

        // directed: idle tick, start with ignored byte, command while busy, stop
        add(KIND_TICK, OP_READ, 8'hFF, 1'b1);
        add(KIND_CMD, OP_START, 8'hFF, 1'b1);
        add(KIND_CMD, OP_READ, 8'h00, 1'b0);
        for (int i = 0; i < LEN_START_STOP; i++) add(KIND_TICK, OP_START, 8'h00, 1'b1);
        add(KIND_TICK, OP_WRITE, 8'h00, 1'b0);
        add(KIND_CMD, OP_STOP, 8'hFF, 1'b0);
        add(KIND_CMD, OP_WRITE, 8'hFF, 1'b1);
        for (int i = 0; i < LEN_START_STOP; i++) add(KIND_TICK, OP_STOP, 8'hFF, 1'b0);
        add(KIND_TICK, OP_START, 8'h00, 1'b1);

        op_no = 0;
        while (plan_q.size() < 1750) begin
            if ($urandom_range(99) < 85) begin
                add_op(t_op'($urandom_range(3)), (op_no % 40) == 0);
                op_no++;
            end else begin
                add(1'($urandom_range(1)), t_op'($urandom_range(3)),
                    8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (plan_q.size() > 0 || cmd_if.valid || pin_levels_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results over %0d transactions: %0d start, %0d stop, %0d write,",
                 checked_cnt, sent_cnt, ops_done[OP_START], ops_done[OP_STOP],
                 ops_done[OP_WRITE]);
        $display("%0d read operations completed, %0d commands rejected while busy",
                 ops_done[OP_READ], rej_cnt);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/i2cms_pkg.sv
sv/i2cms_cmd_if.sv
sv/i2cms_res_if.sv
sv/i2c_master_bit_sequencer.sv
tb/i2c_master_bit_sequencer_tb.sv
